FILE: rtl/skt_pkg.sv
`default_nettype none

package skt_pkg;

   // field widths
   localparam int KEY_WIDTH           = 32;
   localparam int QUANTITY_WIDTH      = 16;
   localparam int PRICE_WIDTH         = 32;
   localparam int ENTRY_COUNT_WIDTH   = 7;

   // default table size
   localparam int TABLE_DEPTH_DEFAULT = 64;

   // or-tree levels between two pipeline registers
   localparam int OR_LEVELS_PER_STAGE = 4;

   // request kinds
   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   // one stored entry
   typedef struct packed {
      logic [KEY_WIDTH-1:0]      key;
      logic [QUANTITY_WIDTH-1:0] quantity;
      logic [PRICE_WIDTH-1:0]    price;
   } entry_type;

   // per-cell lookup contribution, or-reduced over the row
   typedef struct packed {
      logic                      found;
      logic [QUANTITY_WIDTH-1:0] quantity;
      logic [PRICE_WIDTH-1:0]    price;
   } leaf_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                      exec;
      logic                      insert;
      logic                      write_en;
      logic [KEY_WIDTH-1:0]      key;
      logic [QUANTITY_WIDTH-1:0] quantity;
      logic [PRICE_WIDTH-1:0]    price;
   } cell_cmd_type;

   // control sequence
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/sorted_key_table_top.sv
// channel | direction | ports
// req     | in        | req_valid, req_stall, req_kind, req_key, req_new_quantity, req_new_price
// rsp     | out       | rsp_valid, rsp_stall, rsp_found, rsp_found_quantity, rsp_found_price,
//         |           | rsp_rejected_full, rsp_entry_count
//
// each request runs through: transfer, compare and shift in the cell row, the pipelined
// or-tree over the row, result load. the next request is taken only after that load.
// the row of cells inserts in the exec step; the lookup or-tree sets the rest of the wait.
// reset clears the entry count and control; the cells hold no reset state.
// a stalled result holds; a new request is taken while it waits.
`default_nettype none

module sorted_key_table_top #(
   parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_kind,
   input  wire logic [skt_pkg::KEY_WIDTH-1:0]        req_key,
   input  wire logic [skt_pkg::QUANTITY_WIDTH-1:0]   req_new_quantity,
   input  wire logic [skt_pkg::PRICE_WIDTH-1:0]      req_new_price,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_found,
   output logic      [skt_pkg::QUANTITY_WIDTH-1:0]   rsp_found_quantity,
   output logic      [skt_pkg::PRICE_WIDTH-1:0]      rsp_found_price,
   output logic                                      rsp_rejected_full,
   output logic      [skt_pkg::ENTRY_COUNT_WIDTH-1:0] rsp_entry_count
);

   localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
   localparam int OUT_CNT_W     = skt_pkg::ENTRY_COUNT_WIDTH;
   localparam int REDUCE_STAGES = $clog2(TABLE_DEPTH) / skt_pkg::OR_LEVELS_PER_STAGE;
   localparam int WAIT_W        = $clog2(REDUCE_STAGES + 2);
   localparam int LEAF_W        = $bits(skt_pkg::leaf_type);

   skt_pkg::state_type state_ff, state_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic                              kind_ff;
   logic [skt_pkg::KEY_WIDTH-1:0]     key_ff;
   logic [skt_pkg::QUANTITY_WIDTH-1:0] quantity_ff;
   logic [skt_pkg::PRICE_WIDTH-1:0]   price_ff;
   logic                              rej_ff, rej_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              found_ff;
   logic [skt_pkg::QUANTITY_WIDTH-1:0] found_quantity_ff;
   logic [skt_pkg::PRICE_WIDTH-1:0]   found_price_ff;
   logic                              rejected_ff;
   logic [OUT_CNT_W-1:0]              entry_count_ff;

   logic load_req, rsp_load, rsp_free, full, exec, is_insert;

   skt_pkg::cell_cmd_type cmd;
   logic [TABLE_DEPTH-1:0] occ, place, match, hit;
   skt_pkg::entry_type     entries [TABLE_DEPTH];
   logic [LEAF_W-1:0]      leaf_bits [TABLE_DEPTH];
   skt_pkg::leaf_type      tree_root;

   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign exec      = (state_ff == skt_pkg::ST_EXEC);
   assign is_insert = (kind_ff == skt_pkg::KIND_INSERT);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // sequencer: take request, run the row, wait for the tree, load the result
   always_comb begin
      state_in  = state_ff;
      wait_in   = wait_ff;
      req_stall = 1'b1;
      load_req  = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         skt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               load_req = 1'b1;
               state_in = skt_pkg::ST_EXEC;
            end
         end
         skt_pkg::ST_EXEC: begin
            wait_in  = WAIT_W'(REDUCE_STAGES);
            state_in = skt_pkg::ST_FINISH;
         end
         skt_pkg::ST_FINISH: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - 1'b1;
            end else if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = skt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skt_pkg::ST_IDLE;
         end
      endcase
   end

   // entry count and rejected-full flag
   always_comb begin
      count_in = count_ff;
      rej_in   = rej_ff;
      if (exec) begin
         rej_in = is_insert && full;
         if (is_insert && !full) begin
            count_in = CNT_W'(count_ff + 1'b1);
         end
      end
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skt_pkg::ST_IDLE;
         wait_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      rej_ff <= rej_in;
      if (load_req) begin
         kind_ff     <= req_kind;
         key_ff      <= req_key;
         quantity_ff <= req_new_quantity;
         price_ff    <= req_new_price;
      end
      if (rsp_load) begin
         found_ff          <= tree_root.found;
         found_quantity_ff <= tree_root.quantity;
         found_price_ff    <= tree_root.price;
         rejected_ff       <= rej_ff;
         entry_count_ff    <= OUT_CNT_W'(count_ff);
      end
   end

   // command to the row
   always_comb begin
      cmd.exec     = exec;
      cmd.insert   = is_insert;
      cmd.write_en = exec && is_insert && !full;
      cmd.key      = key_ff;
      cmd.quantity = quantity_ff;
      cmd.price    = price_ff;
   end

   // row of cells, each linked to the one below
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic               prev_place, prev_match;
      skt_pkg::entry_type prev_entry;

      assign occ[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign prev_place = 1'b0;
         assign prev_match = 1'b0;
         assign prev_entry = '0;
      end else begin : g_rest
         assign prev_place = place[i-1];
         assign prev_match = match[i-1];
         assign prev_entry = entries[i-1];
      end

      skt_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .occupied   (occ[i]),
         .prev_place (prev_place),
         .prev_match (prev_match),
         .prev_entry (prev_entry),
         .place      (place[i]),
         .match      (match[i]),
         .hit        (hit[i]),
         .entry      (entries[i]),
         .leaf       (leaf_bits[i])
      );
   end

   // lookup result gathered over the row
   skt_or_tree #(
      .LEAF_COUNT (TABLE_DEPTH),
      .WIDTH      (LEAF_W)
   ) u_or_tree (
      .clock  (clock),
      .leaves (leaf_bits),
      .root   (tree_root)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = found_ff;
   assign rsp_found_quantity = found_quantity_ff;
   assign rsp_found_price    = found_price_ff;
   assign rsp_rejected_full  = rejected_ff;
   assign rsp_entry_count    = entry_count_ff;

   // count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table size");

   // an accepted insert into a non-full table adds exactly one entry
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (exec && is_insert && !full) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not add one entry");

   // at most one cell reports the first match
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      exec |-> $onehot0(hit))
      else $error("more than one cell hit");

   // requests are only taken while the sequencer is idle
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != skt_pkg::ST_IDLE) |-> req_stall)
      else $error("request taken while busy");

endmodule

`default_nettype wire

FILE: rtl/skt_cell.sv
`default_nettype none

module skt_cell (
   input  wire logic                clock,
   input  wire skt_pkg::cell_cmd_type cmd,
   input  wire logic                occupied,
   input  wire logic                prev_place,
   input  wire logic                prev_match,
   input  wire skt_pkg::entry_type  prev_entry,
   output logic                     place,
   output logic                     match,
   output logic                     hit,
   output skt_pkg::entry_type       entry,
   output skt_pkg::leaf_type        leaf
);

   skt_pkg::entry_type entry_ff, entry_in;
   skt_pkg::leaf_type  leaf_ff, leaf_in;

   // new key goes at or below this cell: empty, or stored key strictly greater
   assign place = !occupied || (entry_ff.key > cmd.key);

   // equal keys form one run, so only its lowest cell reports
   assign match = occupied && (entry_ff.key == cmd.key);
   assign hit   = match && !prev_match;

   // insert: lowest placing cell takes the new entry, the ones above shift up
   always_comb begin
      entry_in = entry_ff;
      if (cmd.write_en && place) begin
         if (prev_place) begin
            entry_in = prev_entry;
         end else begin
            entry_in.key      = cmd.key;
            entry_in.quantity = cmd.quantity;
            entry_in.price    = cmd.price;
         end
      end
   end

   // lookup contribution, held until the next command
   always_comb begin
      leaf_in = leaf_ff;
      if (cmd.exec) begin
         leaf_in = '0;
         if (!cmd.insert && hit) begin
            leaf_in.found    = 1'b1;
            leaf_in.quantity = entry_ff.quantity;
            leaf_in.price    = entry_ff.price;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      leaf_ff  <= leaf_in;
   end

   assign entry = entry_ff;
   assign leaf  = leaf_ff;

endmodule

`default_nettype wire

FILE: rtl/skt_or_tree.sv
`default_nettype none

module skt_or_tree #(
   parameter int LEAF_COUNT = skt_pkg::TABLE_DEPTH_DEFAULT,
   parameter int WIDTH      = $bits(skt_pkg::leaf_type)
) (
   input  wire logic             clock,
   input  wire logic [WIDTH-1:0] leaves [LEAF_COUNT],
   output logic      [WIDTH-1:0] root
);

   localparam int LEVELS = $clog2(LEAF_COUNT);
   localparam int P2     = 1 << LEVELS;

   // heap order: node n has children 2n and 2n+1, leaves at P2 and up
   logic [WIDTH-1:0] node [1:2*P2-1];

   // leaves, padded with zeros up to a power of two
   for (genvar i = 0; i < P2; i++) begin : g_leaf
      if (i < LEAF_COUNT) begin : g_used
         assign node[P2+i] = leaves[i];
      end else begin : g_pad
         assign node[P2+i] = '0;
      end
   end

   // or levels, registered after every few levels
   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      localparam bit REGISTERED =
         (l % skt_pkg::OR_LEVELS_PER_STAGE) == (skt_pkg::OR_LEVELS_PER_STAGE - 1);
      for (genvar j = 0; j < (P2 >> (l + 1)); j++) begin : g_node
         localparam int N = (P2 >> (l + 1)) + j;
         if (REGISTERED) begin : g_reg
            logic [WIDTH-1:0] node_ff;
            always_ff @(posedge clock) begin
               node_ff <= node[2*N] | node[2*N+1];
            end
            assign node[N] = node_ff;
         end else begin : g_comb
            assign node[N] = node[2*N] | node[2*N+1];
         end
      end
   end

   assign root = node[1];

endmodule

`default_nettype wire

FILE: tb/tb_sorted_key_table_top.sv
module tb_sorted_key_table_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH   = skt_pkg::TABLE_DEPTH_DEFAULT;
   localparam int KEY_W         = skt_pkg::KEY_WIDTH;
   localparam int QTY_W         = skt_pkg::QUANTITY_WIDTH;
   localparam int PRICE_W       = skt_pkg::PRICE_WIDTH;
   localparam int COUNT_W       = skt_pkg::ENTRY_COUNT_WIDTH;
   localparam int RANDOM_COUNT  = 680;
   localparam int QUIET_FIRST   = 100;
   localparam int QUIET_LAST    = 219;
   localparam int IDLE_PERCENT  = 34;
   localparam int DRAIN_CYCLES  = 16;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RESET_CYCLES  = 6;

   // one result as the block reports it
   typedef struct packed {
      logic               found;
      logic [QTY_W-1:0]   quantity;
      logic [PRICE_W-1:0] price;
      logic               rejected_full;
      logic [COUNT_W-1:0] entry_count;
   } table_result_type;

   // one directed row: request, and a typed-in result where it is obvious
   typedef struct packed {
      logic               kind;
      logic [KEY_W-1:0]   key;
      logic [QTY_W-1:0]   quantity;
      logic [PRICE_W-1:0] price;
      logic               typed;
      table_result_type   result;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 22;

   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // empty table lookups, payload ignored
      '{skt_pkg::KIND_LOOKUP, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1,
        '{1'b0, 16'h0, 32'h0, 1'b0, 7'd0}},
      '{skt_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
        '{1'b0, 16'h0, 32'h0, 1'b0, 7'd0}},
      // extremes of every field
      '{skt_pkg::KIND_INSERT, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1,
        '{1'b0, 16'h0, 32'h0, 1'b0, 7'd1}},
      '{skt_pkg::KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
        '{1'b0, 16'h0, 32'h0, 1'b0, 7'd2}},
      '{skt_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000, 1'b1,
        '{1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 7'd2}},
      '{skt_pkg::KIND_LOOKUP, 32'h0000_0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
        '{1'b1, 16'h0, 32'h0, 1'b0, 7'd2}},
      // misses next to stored keys
      '{skt_pkg::KIND_LOOKUP, 32'h0000_0001, 16'h0000, 32'h0000_0000, 1'b1,
        '{1'b0, 16'h0, 32'h0, 1'b0, 7'd2}},
      '{skt_pkg::KIND_LOOKUP, 32'hFFFF_FFFE, 16'h0000, 32'h0000_0000, 1'b1,
        '{1'b0, 16'h0, 32'h0, 1'b0, 7'd2}},
      // equal keys land after the earlier one, lookup returns the first
      '{skt_pkg::KIND_INSERT, 32'h8000_0000, 16'h0001, 32'h0000_0064, 1'b0, '0},
      '{skt_pkg::KIND_INSERT, 32'h8000_0000, 16'h0002, 32'h0000_00C8, 1'b0, '0},
      '{skt_pkg::KIND_LOOKUP, 32'h8000_0000, 16'h0000, 32'h0000_0000, 1'b0, '0},
      '{skt_pkg::KIND_INSERT, 32'h0000_0000, 16'h5555, 32'hAAAA_AAAA, 1'b0, '0},
      '{skt_pkg::KIND_LOOKUP, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b0, '0},
      '{skt_pkg::KIND_INSERT, 32'hFFFF_FFFF, 16'hAAAA, 32'h5555_5555, 1'b0, '0},
      '{skt_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000, 1'b0, '0},
      // inserts in the middle shift the upper entries
      '{skt_pkg::KIND_INSERT, 32'h7FFF_FFFF, 16'h1234, 32'h0001_86A0, 1'b0, '0},
      '{skt_pkg::KIND_INSERT, 32'h8000_0001, 16'hFFFF, 32'h0000_0001, 1'b0, '0},
      '{skt_pkg::KIND_LOOKUP, 32'h7FFF_FFFF, 16'h0000, 32'h0000_0000, 1'b0, '0},
      '{skt_pkg::KIND_LOOKUP, 32'h8000_0001, 16'h0000, 32'h0000_0000, 1'b0, '0},
      '{skt_pkg::KIND_LOOKUP, 32'h8000_0002, 16'h0000, 32'h0000_0000, 1'b0, '0},
      '{skt_pkg::KIND_INSERT, 32'h0000_0001, 16'h8000, 32'h8000_0000, 1'b0, '0},
      '{skt_pkg::KIND_LOOKUP, 32'h0000_0001, 16'h0000, 32'h0000_0000, 1'b0, '0}
   };

   // block ports
   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic               req_kind         = skt_pkg::KIND_LOOKUP;
   logic [KEY_W-1:0]   req_key          = '0;
   logic [QTY_W-1:0]   req_new_quantity = '0;
   logic [PRICE_W-1:0] req_new_price    = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic               rsp_found;
   logic [QTY_W-1:0]   rsp_found_quantity;
   logic [PRICE_W-1:0] rsp_found_price;
   logic               rsp_rejected_full;
   logic [COUNT_W-1:0] rsp_entry_count;

   // shadow copy of the sorted table
   logic [KEY_W-1:0]   held_keys       [TABLE_DEPTH];
   logic [QTY_W-1:0]   held_quantities [TABLE_DEPTH];
   logic [PRICE_W-1:0] held_prices     [TABLE_DEPTH];
   int                 entries_held = 0;

   table_result_type pending_results [$];
   int               error_count   = 0;
   int               cycle_count   = 0;
   bit               quiet_stretch = 1'b0;

   sorted_key_table_top #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_key           (req_key),
      .req_new_quantity  (req_new_quantity),
      .req_new_price     (req_new_price),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_found_quantity(rsp_found_quantity),
      .rsp_found_price   (rsp_found_price),
      .rsp_rejected_full (rsp_rejected_full),
      .rsp_entry_count   (rsp_entry_count)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // apply one operation to the shadow table and return its result
   function automatic table_result_type apply_table_op(input logic kind,
                                                       input logic [KEY_W-1:0] key,
                                                       input logic [QTY_W-1:0] quantity,
                                                       input logic [PRICE_W-1:0] price);
      table_result_type res;
      int               pos;
      res = '0;
      if (kind == skt_pkg::KIND_LOOKUP) begin
         // lowest-placed match wins
         for (int i = 0; i < entries_held && !res.found; i++) begin
            if (held_keys[i] == key) begin
               res.found    = 1'b1;
               res.quantity = held_quantities[i];
               res.price    = held_prices[i];
            end
         end
      end else if (entries_held >= TABLE_DEPTH) begin
         res.rejected_full = 1'b1;
      end else begin
         // first key strictly greater, so equal keys stay ahead
         pos = entries_held;
         for (int i = entries_held - 1; i >= 0; i--) begin
            if (held_keys[i] > key) pos = i;
         end
         for (int j = entries_held; j > pos; j--) begin
            held_keys[j]       = held_keys[j-1];
            held_quantities[j] = held_quantities[j-1];
            held_prices[j]     = held_prices[j-1];
         end
         held_keys[pos]       = key;
         held_quantities[pos] = quantity;
         held_prices[pos]     = price;
         entries_held++;
      end
      res.entry_count = COUNT_W'(entries_held);
      return res;
   endfunction

   // key mix: stored keys, their neighbors, extremes and noise
   function automatic logic [KEY_W-1:0] pick_key(input int hit_percent);
      int               roll;
      logic [KEY_W-1:0] base;
      roll = $urandom_range(99);
      base = (entries_held > 0) ? held_keys[$urandom_range(entries_held - 1)] : $urandom();
      if (roll < hit_percent) return base;
      if (roll < hit_percent + 15) return $urandom_range(1) ? base + 1'b1 : base - 1'b1;
      if (roll < hit_percent + 25) return $urandom_range(1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
      return $urandom();
   endfunction

   function automatic logic [QTY_W-1:0] pick_quantity();
      unique case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return QTY_W'($urandom());
      endcase
   endfunction

   function automatic logic [PRICE_W-1:0] pick_price();
      unique case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // one request transfer, with random idle cycles ahead of it
   task automatic send_table_op(input logic kind,
                                input logic [KEY_W-1:0] key,
                                input logic [QTY_W-1:0] quantity,
                                input logic [PRICE_W-1:0] price,
                                input logic typed,
                                input table_result_type typed_result);
      table_result_type predicted;
      while (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_key          <= key;
      req_new_quantity <= quantity;
      req_new_price    <= price;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_table_op(kind, key, quantity, price);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   // cycle counter
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // result side backpressure
   always @(posedge clock) begin
      rsp_stall <= !reset && !quiet_stretch && ($urandom_range(99) < IDLE_PERCENT);
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin : result_check
      table_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing pending");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_found);
               error_count++;
            end
            if (rsp_found_quantity !== want.quantity) begin
               $error("found_quantity: expected 0x%h, actual 0x%h",
                      want.quantity, rsp_found_quantity);
               error_count++;
            end
            if (rsp_found_price !== want.price) begin
               $error("found_price: expected 0x%h, actual 0x%h", want.price, rsp_found_price);
               error_count++;
            end
            if (rsp_rejected_full !== want.rejected_full) begin
               $error("rejected_full: expected %0d, actual %0d",
                      want.rejected_full, rsp_rejected_full);
               error_count++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, actual %0d", want.entry_count, rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   // stimulus
   initial begin : stimulus
      int   random_done;
      int   insert_percent;
      logic kind;
      random_done = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         send_table_op(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].quantity,
                       DIRECTED_ROWS[r].price, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].result);
      end

      // hold off until every pending result has come back
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);

      // random part: fill the table among lookups, then keep going while full
      while (entries_held < TABLE_DEPTH || random_done < RANDOM_COUNT) begin
         quiet_stretch  = (random_done >= QUIET_FIRST && random_done <= QUIET_LAST);
         insert_percent = (entries_held < TABLE_DEPTH) ? 20 : 40;
         kind = ($urandom_range(99) < insert_percent) ? skt_pkg::KIND_INSERT
                                                      : skt_pkg::KIND_LOOKUP;
         send_table_op(kind, pick_key((kind == skt_pkg::KIND_LOOKUP) ? 55 : 25),
                       pick_quantity(), pick_price(), 1'b0, '0);
         random_done++;
      end
      quiet_stretch = 1'b0;

      // drain
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_sorted_key_table_top: PASS");
      end else begin
         $display("tb_sorted_key_table_top: FAIL");
      end
      $finish;
   end

   // timeout
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("tb_sorted_key_table_top: FAIL");
      $finish;
   end

endmodule
